/* hdl/stuv_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and single-step helpers for the sphere uv mapper
// no dependencies; imported by every module of the block

package stuv_pkg;

  localparam int PosW      = 24;
  localparam int MagW      = PosW + 1;
  localparam int SqW       = 2 * MagW;
  localparam int RootW     = MagW;
  localparam int RemW      = RootW + 4;
  localparam int AxW       = 18;
  localparam int NW        = 18;
  localparam int QuoW      = 17;
  localparam int DivW      = 42;
  localparam int ProdW     = 2 * AxW;
  localparam int AccW      = ProdW + 2;
  localparam int DotW      = 22;
  localparam int UvFrac    = 16;
  localparam int UvW       = UvFrac + 1;
  localparam int AngBits   = 24;
  localparam int CordW     = 34;
  localparam int AngW      = 27;
  localparam int CordSteps = 22;
  localparam int CordPre   = 12;
  localparam int CfgIdxW   = 3;
  localparam int CfgW      = 3 * AxW;
  localparam int EpsInt    = ((1 << UvFrac) + 99999) / 100000;

  // total register stages from input beat to output register
  localparam int Lat = 3 + RootW + QuoW + 4 + RootW + 1 + RootW + 1 + CordSteps + 1;

  localparam logic [UvW-1:0] UvOne  = UvW'(1) << UvFrac;
  localparam logic [UvW-1:0] UvHalf = UvOne >> 1;
  localparam logic [UvW-1:0] UvEps  = UvW'(EpsInt);
  localparam logic [AxW-1:0] AxOne  = AxW'(1) << 16;
  localparam logic [AngW-1:0] AngQuarter = AngW'(1) << (AngBits - 1);
  localparam logic [AngW-1:0] AngHalf    = AngW'(1) << AngBits;

  localparam logic [22:0] ATAN_TAB [CordSteps] = '{
    23'd4194304, 23'd2476042, 23'd1308273, 23'd664100, 23'd333339, 23'd166832,
    23'd83436, 23'd41721, 23'd20861, 23'd10430, 23'd5215, 23'd2608, 23'd1304,
    23'd652, 23'd326, 23'd163, 23'd81, 23'd41, 23'd20, 23'd10, 23'd5, 23'd3
  };

  typedef enum logic [CfgIdxW-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_AXIS_U   = 3'd3,
    REG_AXIS_V   = 3'd4,
    REG_AXIS_N   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0][PosW-1:0]       center;
    logic [2:0][2:0][AxW-1:0]   axis;
  } cfg_t;

  typedef struct packed {
    logic [SqW-1:0]   rad;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [DivW-1:0] rem;
    logic [QuoW-1:0] quo;
  } div_t;

  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [AngW-1:0]  z;
    logic                    yz;
    logic                    xn;
  } cord_t;

  // values that ride along the pipeline
  typedef struct packed {
    logic                   zero;
    logic [2:0]             neg;
    logic [2:0][MagW-1:0]   mag;
    logic [RootW-1:0]       lval;
    logic [2:0][NW-1:0]     n;
    logic signed [DotW-1:0] nx;
    logic signed [DotW-1:0] ny;
    logic signed [NW-1:0]   nz;
    logic [QuoW-1:0]        s;
    logic [QuoW-1:0]        y2;
    logic                   gt;
    logic                   lt;
  } side_t;

  // one digit of the square root recurrence
  function automatic sqrt_t sqrt_step(sqrt_t a);
    logic [RemW-1:0] r2;
    logic [RemW-1:0] t;
    sqrt_t o;
    r2 = {a.rem[RemW-3:0], a.rad[SqW-1 -: 2]};
    t  = {{(RemW-RootW-2){1'b0}}, a.root, 2'b01};
    o.rad = {a.rad[SqW-3:0], 2'b00};
    if (r2 >= t) begin
      o.rem  = r2 - t;
      o.root = {a.root[RootW-2:0], 1'b1};
    end else begin
      o.rem  = r2;
      o.root = {a.root[RootW-2:0], 1'b0};
    end
    return o;
  endfunction

  // one quotient bit of a restoring divide
  function automatic div_t div_step(div_t a, logic [RootW-1:0] l, int i);
    logic [DivW-1:0] sub;
    div_t o;
    sub = DivW'(l) << i;
    o = a;
    if (a.rem >= sub) begin
      o.rem = a.rem - sub;
      o.quo = a.quo | (QuoW'(1) << i);
    end
    return o;
  endfunction

  function automatic cord_t cord_init(logic [QuoW-1:0] y, logic signed [NW-1:0] x);
    logic signed [CordW-1:0] xs;
    logic signed [CordW-1:0] ys;
    cord_t o;
    xs = CordW'(x) <<< CordPre;
    ys = $signed(CordW'(y)) <<< CordPre;
    o.yz = (y == '0);
    o.xn = x[NW-1];
    if (x[NW-1]) begin
      o.x = ys;
      o.y = -xs;
      o.z = $signed(AngQuarter);
    end else begin
      o.x = xs;
      o.y = ys;
      o.z = '0;
    end
    return o;
  endfunction

  function automatic cord_t cord_step(cord_t a, int i);
    logic signed [CordW-1:0] dx;
    logic signed [CordW-1:0] dy;
    logic signed [AngW-1:0]  at;
    cord_t o;
    dx = a.x >>> i;
    dy = a.y >>> i;
    at = $signed(AngW'(ATAN_TAB[i]));
    o = a;
    if (!a.y[CordW-1]) begin
      o.x = a.x + dy;
      o.y = a.y - dx;
      o.z = a.z + at;
    end else begin
      o.x = a.x - dy;
      o.y = a.y + dx;
      o.z = a.z - at;
    end
    return o;
  endfunction

  // angle of a finished rotation, with the on-axis case patched in
  function automatic logic signed [AngW-1:0] cord_angle(cord_t a);
    logic signed [AngW-1:0] r;
    if (a.yz) begin
      r = a.xn ? $signed(AngHalf) : '0;
    end else begin
      r = a.z;
    end
    return r;
  endfunction

  function automatic logic [UvW-1:0] round_clamp(logic signed [AngW-1:0] z, int sh,
                                                 logic [UvW-1:0] hi);
    logic signed [AngW-1:0] r;
    logic [UvW-1:0] res;
    r = (z + $signed(AngW'(1) << (sh - 1))) >>> sh;
    if (z <= 0) begin
      res = '0;
    end else if (r > $signed(AngW'(hi))) begin
      res = hi;
    end else begin
      res = r[UvW-1:0];
    end
    return res;
  endfunction

endpackage

/* hdl/stuv_datapath.sv */
`timescale 1ns / 1ps
// stalling datapath of the sphere uv mapper: normalize, project, two cordics
// depends on stuv_pkg

module stuv_datapath import stuv_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            in_valid_i,
  input  cfg_t            cfg_i,
  input  logic [PosW-1:0] pos_x_i,
  input  logic [PosW-1:0] pos_y_i,
  input  logic [PosW-1:0] pos_z_i,
  output logic            out_valid_o,
  output logic [UvW-1:0]  u_coord_o,
  output logic [UvW-1:0]  v_coord_o,
  output logic            at_center_o
);

  logic [Lat-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  assign out_valid_o = vld_q[Lat-1];

  // difference to centre
  logic [2:0][PosW-1:0]   pos_w;
  logic signed [MagW-1:0] dif_w [3];
  side_t                  a_d, a_q;

  assign pos_w = {pos_z_i, pos_y_i, pos_x_i};

  always_comb begin
    a_d = '0;
    for (int k = 0; k < 3; k++) begin
      dif_w[k] = $signed({pos_w[k][PosW-1], pos_w[k]})
               - $signed({cfg_i.center[k][PosW-1], cfg_i.center[k]});
      a_d.neg[k] = dif_w[k][MagW-1];
      a_d.mag[k] = dif_w[k][MagW-1] ? MagW'(-dif_w[k]) : MagW'(dif_w[k]);
    end
    a_d.zero = (a_d.mag == '0);
  end

  // squares and their sum
  logic [SqW-1:0] sq_q [3];
  logic [SqW-1:0] sum_q;
  side_t          b_q, c_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= a_d;
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= a_q.mag[k] * a_q.mag[k];
      end
      b_q   <= a_q;
      sum_q <= sq_q[0] + sq_q[1] + sq_q[2];
      c_q   <= b_q;
    end
  end

  // length, one root bit a stage
  sqrt_t rl_q [RootW];
  side_t sl_q [RootW];
  sqrt_t rl_init;

  assign rl_init = '{rad: sum_q, rem: '0, root: '0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rl_q[0] <= sqrt_step(rl_init);
      sl_q[0] <= c_q;
      for (int k = 1; k < RootW; k++) begin
        rl_q[k] <= sqrt_step(rl_q[k-1]);
        sl_q[k] <= sl_q[k-1];
      end
    end
  end

  // unit vector, three lanes of restoring divide with half-up rounding
  div_t  dv_init [3];
  div_t  dv_q [QuoW][3];
  side_t sd_q [QuoW];
  side_t sd_init;

  always_comb begin
    sd_init      = sl_q[RootW-1];
    sd_init.lval = rl_q[RootW-1].root;
    for (int ln = 0; ln < 3; ln++) begin
      dv_init[ln].rem = (DivW'(sd_init.mag[ln]) << 16) + DivW'(sd_init.lval >> 1);
      dv_init[ln].quo = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int ln = 0; ln < 3; ln++) begin
        dv_q[0][ln] <= div_step(dv_init[ln], sd_init.lval, QuoW - 1);
      end
      sd_q[0] <= sd_init;
      for (int k = 1; k < QuoW; k++) begin
        for (int ln = 0; ln < 3; ln++) begin
          dv_q[k][ln] <= div_step(dv_q[k-1][ln], sd_q[k-1].lval, QuoW - 1 - k);
        end
        sd_q[k] <= sd_q[k-1];
      end
    end
  end

  // signs back on, dot products with the three axes, pole clamp, nz squared
  side_t f_d, f_q, g_q, h_d, h_q, h2_q;
  logic signed [ProdW-1:0] pr_q [3][3];
  logic signed [AccW-1:0]  acc_w [3];
  logic signed [DotW-1:0]  dot_w [3];
  logic signed [ProdW-1:0] nzsq_q;

  always_comb begin
    f_d = sd_q[QuoW-1];
    for (int k = 0; k < 3; k++) begin
      f_d.n[k] = f_d.neg[k] ? NW'(-{1'b0, dv_q[QuoW-1][k].quo})
                            : NW'({1'b0, dv_q[QuoW-1][k].quo});
    end
  end

  always_comb begin
    h_d = g_q;
    for (int r = 0; r < 3; r++) begin
      acc_w[r] = AccW'(pr_q[r][0]) + AccW'(pr_q[r][1]) + AccW'(pr_q[r][2])
               + $signed(AccW'(32768));
      dot_w[r] = DotW'(acc_w[r] >>> 16);
    end
    h_d.nx = dot_w[0];
    h_d.ny = dot_w[1];
    if (dot_w[2] > $signed(DotW'(AxOne))) begin
      h_d.nz = $signed(AxOne);
    end else if (dot_w[2] < -$signed(DotW'(AxOne))) begin
      h_d.nz = -$signed(AxOne);
    end else begin
      h_d.nz = dot_w[2][NW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_q <= f_d;
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          pr_q[r][j] <= $signed(cfg_i.axis[r][j]) * $signed(f_q.n[j]);
        end
      end
      g_q    <= f_q;
      h_q    <= h_d;
      nzsq_q <= h_q.nz * h_q.nz;
      h2_q   <= h_q;
    end
  end

  // sine of the latitude
  sqrt_t rs_q [RootW];
  side_t ss_q [RootW];
  sqrt_t rs_init;

  assign rs_init = '{rad: (SqW'(1) << 32) - SqW'(nzsq_q[32:0]), rem: '0, root: '0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rs_q[0] <= sqrt_step(rs_init);
      ss_q[0] <= h2_q;
      for (int k = 1; k < RootW; k++) begin
        rs_q[k] <= sqrt_step(rs_q[k-1]);
        ss_q[k] <= ss_q[k-1];
      end
    end
  end

  // longitude leg: s^2 - nx^2 and range checks
  side_t                   j_d, j_q;
  logic [2*QuoW-1:0]       s2_q;
  logic signed [ProdW-1:0] nx2_q;
  logic signed [NW-1:0]    nxt_w;

  assign nxt_w = j_d.nx[NW-1:0];

  always_comb begin
    j_d    = ss_q[RootW-1];
    j_d.s  = rs_q[RootW-1].root[QuoW-1:0];
    j_d.gt = j_d.nx > $signed({1'b0, j_d.s});
    j_d.lt = j_d.nx < -$signed({1'b0, j_d.s});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      j_q   <= j_d;
      s2_q  <= j_d.s * j_d.s;
      nx2_q <= nxt_w * nxt_w;
    end
  end

  sqrt_t ry_q [RootW];
  side_t sy_q [RootW];
  sqrt_t ry_init;

  assign ry_init = '{rad: SqW'(s2_q - nx2_q[2*QuoW-1:0]), rem: '0, root: '0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ry_q[0] <= sqrt_step(ry_init);
      sy_q[0] <= j_q;
      for (int k = 1; k < RootW; k++) begin
        ry_q[k] <= sqrt_step(ry_q[k-1]);
        sy_q[k] <= sy_q[k-1];
      end
    end
  end

  // two cordics side by side: lane 0 latitude, lane 1 longitude
  side_t cs_d;
  side_t cs_q [CordSteps+1];
  cord_t co_q [CordSteps+1][2];

  always_comb begin
    cs_d    = sy_q[RootW-1];
    cs_d.y2 = ry_q[RootW-1].root[QuoW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      co_q[0][0] <= cord_init(cs_d.s, -cs_d.nz);
      co_q[0][1] <= cord_init(cs_d.y2, cs_d.nx[NW-1:0]);
      cs_q[0]    <= cs_d;
      for (int k = 1; k <= CordSteps; k++) begin
        co_q[k][0] <= cord_step(co_q[k-1][0], k - 1);
        co_q[k][1] <= cord_step(co_q[k-1][1], k - 1);
        cs_q[k]    <= cs_q[k-1];
      end
    end
  end

  // rounding, pole and mirror handling
  side_t           fin_w;
  logic [UvW-1:0]  v_w, th_w, u_w;
  logic [UvW-1:0]  u_q, v_q;
  logic            at_q;

  always_comb begin
    fin_w = cs_q[CordSteps];
    v_w   = round_clamp(cord_angle(co_q[CordSteps][0]), AngBits - UvFrac, UvOne);
    if (fin_w.gt) begin
      th_w = '0;
    end else if (fin_w.lt) begin
      th_w = UvHalf;
    end else begin
      th_w = round_clamp(cord_angle(co_q[CordSteps][1]), AngBits + 1 - UvFrac, UvHalf);
    end
    if (v_w < UvEps || v_w > UvOne - UvEps || fin_w.s == '0) begin
      u_w = '0;
    end else begin
      u_w = (fin_w.ny > 0) ? th_w : UvOne - th_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q  <= fin_w.zero ? '0 : u_w;
      v_q  <= fin_w.zero ? '0 : v_w;
      at_q <= fin_w.zero;
    end
  end

  assign u_coord_o   = u_q;
  assign v_coord_o   = v_q;
  assign at_center_o = at_q;

endmodule

/* hdl/sphere_texture_uv_mapping_top.sv */
`timescale 1ns / 1ps
// top level of the spherical texture mapper: config registers and handshake
// depends on stuv_pkg and stuv_datapath
//
//  port group   dir   handshake              payload
//  in           in    in_valid_i/in_ready_o  pos_x_i, pos_y_i, pos_z_i
//  out          out   out_valid_o/out_ready_i u_coord_o, v_coord_o, at_center_o
//  cfg          in    cfg_we_i (no wait)     cfg_idx_i, cfg_data_i
//
// one beat per cycle in and out while the output is not stalled; the pipeline depth
// is set by the three pipelined square roots (25 stages each), the 17-stage divide and
// the 22-stage cordic pair
// a stalled output freezes the whole pipeline in place; valid bits ride with
// the data so nothing is dropped or repeated
// reset clears valid bits and loads the default centre and axes

module sphere_texture_uv_mapping_top import stuv_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [PosW-1:0]    pos_x_i,
  input  logic [PosW-1:0]    pos_y_i,
  input  logic [PosW-1:0]    pos_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [UvW-1:0]     u_coord_o,
  output logic [UvW-1:0]     v_coord_o,
  output logic               at_center_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  logic [2:0][PosW-1:0]     center_q;
  logic [2:0][2:0][AxW-1:0] axis_q;
  cfg_t                     cfg_w;
  logic                     en_w;
  logic                     dp_valid_w;

  // register writes, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= '0;
      // unit axes: u along x, v along y, pole along z
      axis_q   <= '{'{AxOne, '0, '0}, '{'0, AxOne, '0}, '{'0, '0, AxOne}};
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_CENTER_X: center_q[0] <= cfg_data_i[PosW-1:0];
        REG_CENTER_Y: center_q[1] <= cfg_data_i[PosW-1:0];
        REG_CENTER_Z: center_q[2] <= cfg_data_i[PosW-1:0];
        REG_AXIS_U:   axis_q[0]   <= cfg_data_i;
        REG_AXIS_V:   axis_q[1]   <= cfg_data_i;
        REG_AXIS_N:   axis_q[2]   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_w.center = center_q;
  assign cfg_w.axis   = axis_q;

  // advance whenever the output register is empty or being drained
  assign en_w        = !dp_valid_w || out_ready_i;
  assign in_ready_o  = en_w;
  assign out_valid_o = dp_valid_w;

  stuv_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en_w),
    .in_valid_i  (in_valid_i),
    .cfg_i       (cfg_w),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .pos_z_i     (pos_z_i),
    .out_valid_o (dp_valid_w),
    .u_coord_o   (u_coord_o),
    .v_coord_o   (v_coord_o),
    .at_center_o (at_center_o)
  );

endmodule

/* hdl/stuv_checker.sv */
`timescale 1ns / 1ps
// port-level checks for the sphere uv mapper, bound to the top level
// depends on stuv_pkg and sphere_texture_uv_mapping_top

module stuv_checker import stuv_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [PosW-1:0]    pos_x_i,
  input logic [PosW-1:0]    pos_y_i,
  input logic [PosW-1:0]    pos_z_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [UvW-1:0]     u_coord_o,
  input logic [UvW-1:0]     v_coord_o,
  input logic               at_center_o,
  input logic               cfg_we_i,
  input logic [CfgIdxW-1:0] cfg_idx_i,
  input logic [CfgW-1:0]    cfg_data_i
);

  // centre hits come out as zero coordinates
  a_center_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && at_center_o |-> u_coord_o == '0 && v_coord_o == '0)
    else $error("center beat with nonzero uv");

  // coordinates never exceed one
  a_uv_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> u_coord_o <= UvOne && v_coord_o <= UvOne)
    else $error("uv out of range");

  // an empty output stage never blocks the input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(u_coord_o)
      && $stable(v_coord_o) && $stable(at_center_o))
    else $error("stalled result changed");

endmodule

bind sphere_texture_uv_mapping_top stuv_checker u_stuv_checker (.*);
